[rtl/core/sacl_pkg.sv]
// Shared constants and field widths for the cache tag store.
package sacl_pkg;

	localparam int ADDR_W  = 64;
	localparam int KIND_W  = 2;
	localparam int OUTC_W  = 2;
	localparam int TOTAL_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd3;

	localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

[rtl/core/sacl_in_if.sv]
// Access request channel: kind and byte address.
interface sacl_in_if
	import sacl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink (input valid, input kind, input address, output ready);
endinterface

[rtl/core/sacl_out_if.sv]
// Lookup result channel: outcome, last flag and running totals.
interface sacl_out_if
	import sacl_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OUTC_W-1:0]  outcome;
	logic               last;
	logic [TOTAL_W-1:0] hit_total;
	logic [TOTAL_W-1:0] miss_total;
	logic [TOTAL_W-1:0] eviction_total;

	modport source (output valid, output outcome, output last, output hit_total,
		output miss_total, output eviction_total, input ready);
	modport sink (input valid, input outcome, input last, input hit_total,
		input miss_total, input eviction_total, output ready);
endinterface

[rtl/core/set_assoc_cache_lru_model.sv]
// Set-associative LRU tag store: set memory, lookup sequencer and result register.
//
//  channel  | direction | transfer carries
//  ---------+-----------+-----------------------------------------------------
//  req      | in        | kind, address
//  rsp      | out       | outcome, last, hit_total, miss_total, eviction_total
//  cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// The set row is read from the set memory when a load or store is accepted, and
// it is compared, updated and written back in the lookup state. A modify looks
// up twice, as its second lookup reads the row again after the first write-back.
// After reset a clearing pass writes every set row once before the first request
// transfer. A full result register stalls the lookup state; a new request is
// taken while a result still waits.
module set_assoc_cache_lru_model
	import sacl_pkg::*;
#(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sacl_in_if.sink               req,
	sacl_out_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SETB   = $clog2(MAX_SETS + 1) - 1;
	localparam int SIDX_W = (SETB > 0) ? SETB : 1;
	localparam int ROWS   = 1 << SETB;
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W  = RANK_W;
	localparam int WCNT_W = 5;
	localparam int SHIFT_W = 7;

	localparam logic [RANK_W-1:0]  RANK_TOP = RANK_W'(MAX_WAYS - 1);
	localparam logic [ADDR_W-1:0]  ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
	localparam logic [3:0]         SETB_MAX = 4'(SETB);
	localparam logic [WCNT_W-1:0]  WAYS_MAX = WCNT_W'(MAX_WAYS);
	localparam logic [SIDX_W-1:0]  LAST_ROW = SIDX_W'(ROWS - 1);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOK   = 2'd2;
	localparam logic [1:0] ST_REREAD = 2'd3;

	typedef struct packed {
		logic [MAX_WAYS-1:0]                valid;
		logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
		logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
	} row_t;

	row_t row_mem_q [ROWS];

	logic [1:0]        state_q;
	logic [SIDX_W-1:0] clr_cnt_q;
	logic [3:0]        set_bits_q;
	logic [3:0]        ways_q;
	logic [5:0]        offset_bits_q;

	logic [KIND_W-1:0]    kind_s1;
	logic                 second_s1;
	logic [SIDX_W-1:0]    set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	row_t                 row_s2;

	logic [TOTAL_W-1:0] hits_q;
	logic [TOTAL_W-1:0] misses_q;
	logic [TOTAL_W-1:0] evicts_q;

	logic               out_valid_q;
	logic [OUTC_W-1:0]  outcome_q;
	logic               last_q;

	// Address split for the incoming request.
	logic [3:0]         sb_eff;
	logic [WCNT_W-1:0]  ways_eff;
	logic [ADDR_W-1:0]  addr_cut;
	logic [ADDR_W-1:0]  blk;
	logic [ADDR_W-1:0]  tag_full;
	logic [SIDX_W-1:0]  set_mask;
	logic [SIDX_W-1:0]  req_set;
	logic [SHIFT_W-1:0] tag_shift;

	logic in_xfer;
	logic rd_en;
	logic [SIDX_W-1:0] rd_addr;
	logic wr_en;
	logic [SIDX_W-1:0] wr_addr;
	row_t wr_row;

	// Lookup on the row read back.
	logic [MAX_WAYS-1:0] active;
	logic [MAX_WAYS-1:0] hit_vec;
	logic [MAX_WAYS-1:0] inv_vec;
	logic [MAX_WAYS-1:0] evict_vec;
	logic                hit_any;
	logic                inv_any;
	logic                was_valid;
	logic [WAY_W-1:0]    sel_way;
	logic [RANK_W-1:0]   old_rank;
	row_t                new_row;
	logic [OUTC_W-1:0]   outcome_d;
	logic                last_d;
	logic                can_push;
	logic                look_fire;

	function automatic logic [WAY_W-1:0] first_set(input logic [MAX_WAYS-1:0] vec);
		logic [WAY_W-1:0] idx;
		logic             found;
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (vec[i] && !found) begin
				idx   = WAY_W'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

	assign sb_eff   = (set_bits_q > SETB_MAX) ? SETB_MAX : set_bits_q;
	assign ways_eff = (ways_q == 4'd0) ? WCNT_W'(1) :
		(WCNT_W'(ways_q) > WAYS_MAX) ? WAYS_MAX : WCNT_W'(ways_q);

	assign addr_cut  = req.address & ADDR_MASK;
	assign blk       = addr_cut >> offset_bits_q;
	assign set_mask  = ~({SIDX_W{1'b1}} << sb_eff);
	assign req_set   = blk[SIDX_W-1:0] & set_mask;
	assign tag_shift = SHIFT_W'(offset_bits_q) + SHIFT_W'(sb_eff);
	assign tag_full  = addr_cut >> tag_shift;

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;

	assign can_push  = !out_valid_q || rsp.ready;
	assign look_fire = (state_q == ST_LOOK) && can_push;

	assign rd_en   = (in_xfer && req.kind != KIND_IFETCH) || (state_q == ST_REREAD);
	assign rd_addr = (state_q == ST_REREAD) ? set_s1 : req_set;

	assign wr_en   = (state_q == ST_CLEAR) || look_fire;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q : set_s1;
	assign wr_row  = (state_q == ST_CLEAR) ? row_t'('0) : new_row;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			active[w]  = WCNT_W'(w) < ways_eff;
			hit_vec[w] = active[w] && row_s2.valid[w] && (row_s2.tag[w] == tag_s1);
			inv_vec[w] = active[w] && !row_s2.valid[w];
		end
		// A way is the victim candidate when its rank is the highest and no lower
		// way ties it.
		for (int w = 0; w < MAX_WAYS; w++) begin
			evict_vec[w] = active[w];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (active[j] && j < w && row_s2.rank[j] >= row_s2.rank[w])
					evict_vec[w] = 1'b0;
				if (active[j] && j > w && row_s2.rank[j] > row_s2.rank[w])
					evict_vec[w] = 1'b0;
			end
		end
		hit_any   = |hit_vec;
		inv_any   = |inv_vec;
		was_valid = hit_any || !inv_any;
		if (hit_any)
			sel_way = first_set(hit_vec);
		else if (inv_any)
			sel_way = first_set(inv_vec);
		else
			sel_way = first_set(evict_vec);
		old_rank = row_s2.rank[sel_way];

		new_row = row_s2;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == sel_way) begin
				new_row.rank[w]  = '0;
				new_row.valid[w] = 1'b1;
				new_row.tag[w]   = tag_s1;
			end else if (active[w] && row_s2.valid[w] &&
				(!was_valid || row_s2.rank[w] < old_rank) && row_s2.rank[w] != RANK_TOP) begin
				new_row.rank[w] = row_s2.rank[w] + RANK_W'(1);
			end
		end

		if (hit_any)
			outcome_d = OUTC_HIT;
		else if (inv_any)
			outcome_d = OUTC_FILL;
		else
			outcome_d = OUTC_EVICT;
		last_d = !(kind_s1 == KIND_MODIFY && !second_s1);
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			row_s2 <= row_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			row_mem_q[wr_addr] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 4'd0;
			ways_q        <= 4'd1;
			offset_bits_q <= 6'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data[3:0];
				CFG_WAYS:        ways_q        <= cfg_data[3:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + SIDX_W'(1);
					if (clr_cnt_q == LAST_ROW)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer && req.kind != KIND_IFETCH)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (can_push)
						state_q <= last_d ? ST_IDLE : ST_REREAD;
				end
				ST_REREAD: begin
					state_q <= ST_LOOK;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1   <= req.kind;
			second_s1 <= 1'b0;
			set_s1    <= req_set;
			tag_s1    <= tag_full[ADDR_BITS-1:0];
		end else if (state_q == ST_REREAD) begin
			second_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (look_fire) begin
			if (hit_any) begin
				if (hits_q != TOTAL_MAX)
					hits_q <= hits_q + TOTAL_W'(1);
			end else begin
				if (misses_q != TOTAL_MAX)
					misses_q <= misses_q + TOTAL_W'(1);
				if (!inv_any && evicts_q != TOTAL_MAX)
					evicts_q <= evicts_q + TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (look_fire)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (look_fire) begin
			outcome_q <= outcome_d;
			last_q    <= last_d;
		end
	end

	// The totals registers already hold the counts including the result on show.
	assign rsp.valid          = out_valid_q;
	assign rsp.outcome        = outcome_q;
	assign rsp.last           = last_q;
	assign rsp.hit_total      = hits_q;
	assign rsp.miss_total     = misses_q;
	assign rsp.eviction_total = evicts_q;

endmodule

[tb/set_assoc_cache_lru_model_test.sv]
// Self-checking testbench for the set-associative LRU tag store, with its own LRU predictor.
module set_assoc_cache_lru_model_test
	import sacl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SETS      = 256;
	localparam int MAX_WAYS      = 8;
	localparam int ADDR_BITS     = 64;
	localparam int SET_BITS_MAX  = $clog2(MAX_SETS);
	localparam int LINES         = MAX_SETS * MAX_WAYS;
	localparam int SETTLE_CYCLES = 8;
	localparam int POOL_SIZE     = 2 * MAX_WAYS + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
	localparam logic [2:0]           RANK_OLDEST = 3'(MAX_WAYS - 1);

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
	} access_t;

	typedef struct {
		logic [OUTC_W-1:0]  outcome;
		logic               last;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
		logic [TOTAL_W-1:0] eviction_total;
	} lookup_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sacl_in_if  req_ch ();
	sacl_out_if rsp_ch ();

	set_assoc_cache_lru_model #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: geometry registers, line store and running totals.
	logic [3:0]         set_bits_reg;
	logic [3:0]         ways_reg;
	logic [5:0]         offset_bits_reg;
	bit                 line_live [LINES];
	logic [ADDR_W-1:0]  line_tag [LINES];
	logic [2:0]         line_rank [LINES];
	logic [TOTAL_W-1:0] hits;
	logic [TOTAL_W-1:0] misses;
	logic [TOTAL_W-1:0] evictions;

	access_t           pending_accesses[$];
	lookup_result_t    expected_lookups[$];
	logic [ADDR_W-1:0] tag_pool [POOL_SIZE];
	idle_mode_t        idle_mode;
	bit                req_taken;
	bit                mismatch_seen;

	function automatic int active_set_bits();
		return (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
	endfunction

	function automatic int active_ways();
		if (ways_reg == 0)
			return 1;
		if (ways_reg > MAX_WAYS)
			return MAX_WAYS;
		return int'(ways_reg);
	endfunction

	function automatic logic [TOTAL_W-1:0] saturating_inc(logic [TOTAL_W-1:0] v);
		return (v == TOTAL_MAX) ? v : v + 1'b1;
	endfunction

	// Lines younger than the touched one age by one unless already at the oldest rank;
	// after a fill into an invalid line every other valid line ages the same way.
	function automatic void make_most_recent(int base, int way, int ways, bit was_valid);
		logic [2:0] old_rank;
		old_rank = line_rank[base + way];
		for (int i = 0; i < ways; i++)
			if (i != way && line_live[base + i] &&
				(!was_valid || line_rank[base + i] < old_rank) &&
				line_rank[base + i] < RANK_OLDEST)
				line_rank[base + i]++;
		line_rank[base + way] = '0;
	endfunction

	function automatic logic [OUTC_W-1:0] lookup_line(logic [ADDR_W-1:0] address);
		int                sb;
		int                ways;
		int                base;
		int                victim;
		bit                have_invalid;
		logic [ADDR_W-1:0] block;
		logic [ADDR_W-1:0] tag;
		sb = active_set_bits();
		ways = active_ways();
		block = address >> offset_bits_reg;
		base = int'(block & ((64'd1 << sb) - 1)) * MAX_WAYS;
		tag = block >> sb;
		for (int i = 0; i < ways; i++)
			if (line_live[base + i] && line_tag[base + i] == tag) begin
				make_most_recent(base, i, ways, 1'b1);
				hits = saturating_inc(hits);
				return OUTC_HIT;
			end
		misses = saturating_inc(misses);
		have_invalid = 1'b0;
		victim = 0;
		for (int i = 0; i < ways && !have_invalid; i++)
			if (!line_live[base + i]) begin
				victim = i;
				have_invalid = 1'b1;
			end
		// All lines valid: the oldest rank goes, the lowest way on a tie.
		if (!have_invalid) begin
			for (int i = 1; i < ways; i++)
				if (line_rank[base + i] > line_rank[base + victim])
					victim = i;
			evictions = saturating_inc(evictions);
		end
		make_most_recent(base, victim, ways, !have_invalid);
		line_live[base + victim] = 1'b1;
		line_tag[base + victim] = tag;
		return have_invalid ? OUTC_FILL : OUTC_EVICT;
	endfunction

	function automatic void record_lookup(logic [ADDR_W-1:0] address, bit last_one);
		lookup_result_t r;
		r.outcome = lookup_line(address);
		r.last = last_one;
		r.hit_total = hits;
		r.miss_total = misses;
		r.eviction_total = evictions;
		expected_lookups.push_back(r);
	endfunction

	function automatic void predict_access(access_t a);
		case (a.kind)
			KIND_IFETCH: ;
			KIND_MODIFY: begin
				record_lookup(a.address, 1'b0);
				record_lookup(a.address, 1'b1);
			end
			default: record_lookup(a.address, 1'b1);
		endcase
	endfunction

	// Addresses are built from a small tag pool and few sets so that hits and
	// evictions are frequent; some are fully random.
	function automatic access_t random_access();
		access_t           a;
		int                sb;
		logic [ADDR_W-1:0] tag_part;
		logic [ADDR_W-1:0] set_part;
		logic [ADDR_W-1:0] offset_part;
		case ($urandom_range(0, 9))
			0: a.kind = KIND_IFETCH;
			1, 2: a.kind = KIND_MODIFY;
			3, 4, 5: a.kind = KIND_STORE;
			default: a.kind = KIND_LOAD;
		endcase
		if ($urandom_range(0, 6) == 0) begin
			a.address = {$urandom, $urandom};
		end else begin
			sb = active_set_bits();
			tag_part = tag_pool[$urandom_range(0, 2 * active_ways() + 1)];
			set_part = ($urandom_range(0, 4) == 0) ? 64'($urandom) : 64'($urandom_range(0, 2));
			set_part &= (64'd1 << sb) - 1;
			offset_part = {$urandom, $urandom} & ((64'd1 << offset_bits_reg) - 1);
			a.address = (tag_part << (sb + offset_bits_reg)) |
				(set_part << offset_bits_reg) | offset_part;
		end
		return a;
	endfunction

	function automatic bit pause_now(bit receiver_side);
		case (idle_mode)
			IDLE_SENDER: return !receiver_side && $urandom_range(0, 99) < 80;
			IDLE_RECEIVER: return receiver_side && $urandom_range(0, 99) < 80;
			IDLE_BOTH: return $urandom_range(0, 99) < 21;
			default: return 1'b0;
		endcase
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			CFG_SET_BITS: set_bits_reg = value[3:0];
			CFG_WAYS: ways_reg = value[3:0];
			CFG_OFFSET_BITS: offset_bits_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// An instruction fetch leaves no result behind, so the pause covers a lookup
	// that may still be in flight.
	task automatic wait_until_idle();
		while (pending_accesses.size() != 0 || req_ch.valid || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] ways,
		logic [CFG_DATA_W-1:0] ob);
		write_register(CFG_SET_BITS, sb);
		write_register(CFG_WAYS, ways);
		write_register(CFG_OFFSET_BITS, ob);
	endtask

	task automatic run_random_phase(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] ways,
		logic [CFG_DATA_W-1:0] ob, idle_mode_t mode, int count);
		wait_until_idle();
		set_geometry(sb, ways, ob);
		for (int i = 0; i < POOL_SIZE; i++)
			tag_pool[i] = $urandom_range(0, 1) ? 64'(i) : {$urandom, $urandom};
		idle_mode = mode;
		repeat (count) pending_accesses.push_back(random_access());
	endtask

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		mismatch_seen = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Request driver: a new access goes out only after the previous transfer.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_accesses.size() != 0 && !pause_now(1'b0)) begin
				req_ch.valid <= 1'b1;
				req_ch.kind <= pending_accesses[0].kind;
				req_ch.address <= pending_accesses[0].address;
				void'(pending_accesses.pop_front());
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= arst_n && !pause_now(1'b1);
	end

	always @(posedge clk) begin
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready)
			predict_access(access_t'{req_ch.kind, req_ch.address});
	end

	always @(posedge clk) begin : check_results
		lookup_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_lookups.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual outcome %0d last %0d",
					$time, rsp_ch.outcome, rsp_ch.last);
				mismatch_seen = 1'b1;
			end else begin
				want = expected_lookups.pop_front();
				if (rsp_ch.outcome !== want.outcome)
					report_mismatch("outcome", want.outcome, rsp_ch.outcome);
				if (rsp_ch.last !== want.last)
					report_mismatch("last", want.last, rsp_ch.last);
				if (rsp_ch.hit_total !== want.hit_total)
					report_mismatch("hit_total", want.hit_total, rsp_ch.hit_total);
				if (rsp_ch.miss_total !== want.miss_total)
					report_mismatch("miss_total", want.miss_total, rsp_ch.miss_total);
				if (rsp_ch.eviction_total !== want.eviction_total)
					report_mismatch("eviction_total", want.eviction_total,
						rsp_ch.eviction_total);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SET_BITS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.address = '0;
		rsp_ch.ready = 1'b0;
		idle_mode = IDLE_NONE;
		req_taken = 1'b0;
		mismatch_seen = 1'b0;
		set_bits_reg = '0;
		ways_reg = 4'd1;
		offset_bits_reg = '0;
		for (int i = 0; i < LINES; i++) begin
			line_live[i] = 1'b0;
			line_tag[i] = '0;
			line_rank[i] = '0;
		end
		hits = '0;
		misses = '0;
		evictions = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two sets of two ways with 16-byte blocks: fills, hits, evictions,
		// modifies, fetches and the address extremes.
		set_geometry(6'd1, 6'd2, 6'd4);
		write_register(CFG_UNUSED, 6'h3F);
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h0});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'hF});
		pending_accesses.push_back(access_t'{KIND_STORE, 64'h20});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h40});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h0});
		pending_accesses.push_back(access_t'{KIND_MODIFY, 64'h10});
		pending_accesses.push_back(access_t'{KIND_IFETCH, 64'h20});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF});
		pending_accesses.push_back(access_t'{KIND_STORE, 64'hFFFF_FFFF_FFFF_FFF0});
		pending_accesses.push_back(access_t'{KIND_MODIFY, 64'h8000_0000_0000_0010});
		pending_accesses.push_back(access_t'{KIND_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h40});
		pending_accesses.push_back(access_t'{KIND_STORE, 64'h5555_5555_5555_5555});
		pending_accesses.push_back(access_t'{KIND_STORE, 64'hAAAA_AAAA_AAAA_AAAA});
		pending_accesses.push_back(access_t'{KIND_MODIFY, 64'h5555_5555_5555_5555});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h10});
		pending_accesses.push_back(access_t'{KIND_MODIFY, 64'h0});
		pending_accesses.push_back(access_t'{KIND_STORE, 64'h20});
		pending_accesses.push_back(access_t'{KIND_LOAD, 64'h60});

		run_random_phase(6'd0, 6'd1, 6'd0, IDLE_NONE, 150);
		run_random_phase(6'd8, 6'd8, 6'd32, IDLE_SENDER, 200);
		// Set bits above the limit, zero ways and the widest offset.
		run_random_phase(6'h3F, 6'd0, 6'd63, IDLE_RECEIVER, 150);
		run_random_phase(6'd3, 6'd15, 6'd6, IDLE_BOTH, 200);
		// Shrinking and then growing the ways leaves stale ranks behind, so ties occur.
		run_random_phase(6'd3, 6'd4, 6'd6, IDLE_NONE, 200);
		run_random_phase(6'd3, 6'd8, 6'd6, IDLE_BOTH, 150);
		run_random_phase(6'd2, 6'd5, 6'd12, IDLE_SENDER, 200);
		run_random_phase(6'd4, 6'd3, 6'd2, IDLE_RECEIVER, 180);
		wait_until_idle();

		if (!mismatch_seen)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
